/* hw/rtl/pffrs_pkg.sv */
package pffrs_pkg;

  // Configuration register indexes
  localparam logic CFG_FAULT_INTERVAL = 1'b0;
  localparam logic CFG_PAGE_COUNT     = 1'b1;

  localparam int CFG_DATA_W  = 16;
  localparam int INTERVAL_W  = 16;
  localparam int PAGE_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int TOTAL_W     = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  localparam logic [INTERVAL_W-1:0] FAULT_INTERVAL_RST = 16'd2;
  localparam logic [PAGE_W-1:0]     PAGE_COUNT_RST     = 6'd10;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_faults;
    logic [COUNT_W-1:0] resident_count;
    logic [COUNT_W-1:0] pages_evicted;
    logic               window_trimmed;
    logic               invalid_reference;
    logic               page_fault;
  } result_t;

endpackage

/* hw/rtl/page_fault_frequency_resident_set_core.sv */
// Pipeline: an accepted reference waits in the input register (in_page) until the
// result register (out_result) loads, which waits while the output is stalled.
// Throughput: one page reference per cycle unless the output stalls; the resident/use
// vectors and the resident and unused-page counters are updated in a single pass per
// reference.
// Reset (rst, synchronous): all pages non-resident, counters and fault total zero,
// fault_interval = 2, page_count = 10.
module page_fault_frequency_resident_set_core #(
  parameter int PAGE_SLOTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [pffrs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // page references
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pffrs_pkg::IN_TDATA_W-1:0]     s_tdata,  // [5:0] page_number
  // results
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] page_fault, [1] invalid_reference, [2] window_trimmed,
  // [9:3] pages_evicted, [16:10] resident_count, [48:17] total_faults
  output logic [pffrs_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int IDX_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam logic [pffrs_pkg::COUNT_W-1:0] SLOT_LIMIT = pffrs_pkg::COUNT_W'(PAGE_SLOTS);
  localparam logic [PAGE_SLOTS-1:0] ONE_HOT0 = PAGE_SLOTS'(1);
  localparam int RES_W = $bits(pffrs_pkg::result_t);

  // configuration
  logic [pffrs_pkg::INTERVAL_W-1:0] fault_interval;
  logic [pffrs_pkg::PAGE_W-1:0]     page_count;

  // pipeline registers
  logic                         in_valid;
  logic [pffrs_pkg::PAGE_W-1:0] in_page;
  logic                         out_valid;
  pffrs_pkg::result_t           out_result;

  // state
  logic [PAGE_SLOTS-1:0]            resident_bits, resident_bits_next;
  logic [PAGE_SLOTS-1:0]            use_bits, use_bits_next;
  logic [pffrs_pkg::INTERVAL_W-1:0] refs_since_fault, refs_since_fault_next;
  logic [pffrs_pkg::TOTAL_W-1:0]    fault_total, fault_total_next;
  // res_cnt tracks popcount(resident_bits); unused_cnt tracks popcount(resident & ~use)
  logic [pffrs_pkg::COUNT_W-1:0]    res_cnt, res_cnt_next;
  logic [pffrs_pkg::COUNT_W-1:0]    unused_cnt, unused_cnt_next;

  logic                             advance;
  logic                             valid_ref;
  logic [IDX_W-1:0]                 idx;
  logic [PAGE_SLOTS-1:0]            page_bit;
  logic                             hit;
  logic                             used;
  logic [pffrs_pkg::INTERVAL_W:0]   gap;
  logic                             fault;
  logic                             trim;
  pffrs_pkg::result_t               result;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {(pffrs_pkg::OUT_TDATA_W - RES_W)'(0), out_result};

  assign valid_ref = (in_page <= page_count) && ({1'b0, in_page} < SLOT_LIMIT);
  assign idx       = in_page[IDX_W-1:0];
  assign page_bit  = ONE_HOT0 << idx;
  assign hit       = resident_bits[idx];
  assign used      = use_bits[idx];
  assign gap       = {1'b0, refs_since_fault} + (pffrs_pkg::INTERVAL_W+1)'(1);
  assign fault     = valid_ref && !hit;
  assign trim      = fault && (gap > {1'b0, fault_interval});

  always_comb begin
    resident_bits_next = resident_bits;
    use_bits_next      = use_bits;
    res_cnt_next       = res_cnt;
    unused_cnt_next    = unused_cnt;
    fault_total_next   = fault_total;
    if (refs_since_fault == '1) begin
      refs_since_fault_next = refs_since_fault;
    end else begin
      refs_since_fault_next = gap[pffrs_pkg::INTERVAL_W-1:0];
    end

    if (fault) begin
      refs_since_fault_next = '0;
      use_bits_next         = page_bit;
      if (fault_total != '1) begin
        fault_total_next = fault_total + pffrs_pkg::TOTAL_W'(1);
      end
      if (trim) begin
        // unused resident pages go; survivors lose their use bits
        resident_bits_next = (resident_bits & use_bits) | page_bit;
        res_cnt_next       = res_cnt - unused_cnt + pffrs_pkg::COUNT_W'(1);
        unused_cnt_next    = res_cnt - unused_cnt;
      end else begin
        resident_bits_next = resident_bits | page_bit;
        res_cnt_next       = res_cnt + pffrs_pkg::COUNT_W'(1);
        unused_cnt_next    = res_cnt;
      end
    end else if (valid_ref) begin
      use_bits_next = use_bits | page_bit;
      if (!used) begin
        unused_cnt_next = unused_cnt - pffrs_pkg::COUNT_W'(1);
      end
    end

    result.page_fault        = fault;
    result.invalid_reference = !valid_ref;
    result.window_trimmed    = trim;
    result.pages_evicted     = trim ? unused_cnt : '0;
    result.resident_count    = res_cnt_next;
    result.total_faults      = fault_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_interval   <= pffrs_pkg::FAULT_INTERVAL_RST;
      page_count       <= pffrs_pkg::PAGE_COUNT_RST;
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      resident_bits    <= '0;
      use_bits         <= '0;
      refs_since_fault <= '0;
      fault_total      <= '0;
      res_cnt          <= '0;
      unused_cnt       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pffrs_pkg::CFG_FAULT_INTERVAL: fault_interval <= cfg_data;
          pffrs_pkg::CFG_PAGE_COUNT:     page_count <= cfg_data[pffrs_pkg::PAGE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        resident_bits    <= resident_bits_next;
        use_bits         <= use_bits_next;
        refs_since_fault <= refs_since_fault_next;
        fault_total      <= fault_total_next;
        res_cnt          <= res_cnt_next;
        unused_cnt       <= unused_cnt_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_page <= s_tdata[pffrs_pkg::PAGE_W-1:0];
    end
    if (advance) begin
      out_result <= result;
    end
  end

`ifndef SYNTHESIS
  a_res_cnt_matches: assert property (@(posedge clk) disable iff (rst)
    pffrs_pkg::COUNT_W'($countones(resident_bits)) == res_cnt)
    else $error("resident counter out of step with resident bits");

  a_unused_cnt_matches: assert property (@(posedge clk) disable iff (rst)
    pffrs_pkg::COUNT_W'($countones(resident_bits & ~use_bits)) == unused_cnt)
    else $error("unused counter out of step with resident/use bits");

  a_use_within_resident: assert property (@(posedge clk) disable iff (rst)
    (use_bits & ~resident_bits) == '0)
    else $error("use bit set on a non-resident page");

  a_fault_clears_gap: assert property (@(posedge clk) disable iff (rst)
    (advance && fault) |=> (refs_since_fault == '0) && out_result.page_fault)
    else $error("fault did not restart the reference gap");
`endif

endmodule

/* test/page_fault_frequency_resident_set_core_tb.sv */
`timescale 1ns / 100ps

module page_fault_frequency_resident_set_core_tb;

  // Tracks resident and use bits per page and predicts one result per reference.
  class resident_set_tracker;
    logic [pffrs_pkg::INTERVAL_W-1:0] fault_interval;
    logic [pffrs_pkg::PAGE_W-1:0]     page_count;
    logic [63:0]                      resident;
    logic [63:0]                      used;
    int unsigned                      refs_since_fault;
    logic [pffrs_pkg::TOTAL_W-1:0]    fault_total;
    pffrs_pkg::result_t               expected_results[$];
    int                               mismatches;
    int                               results_seen;
    int                               references;
    int                               faults;
    int                               trims;
    int                               invalid_refs;
    int                               register_writes;

    function new();
      fault_interval   = pffrs_pkg::FAULT_INTERVAL_RST;
      page_count       = pffrs_pkg::PAGE_COUNT_RST;
      resident         = '0;
      used             = '0;
      refs_since_fault = 0;
      fault_total      = '0;
      mismatches       = 0;
      results_seen     = 0;
      references       = 0;
      faults           = 0;
      trims            = 0;
      invalid_refs     = 0;
      register_writes  = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_register(logic index, logic [pffrs_pkg::CFG_DATA_W-1:0] data);
      register_writes++;
      if (index == pffrs_pkg::CFG_FAULT_INTERVAL) begin
        fault_interval = data[pffrs_pkg::INTERVAL_W-1:0];
      end else begin
        page_count = data[pffrs_pkg::PAGE_W-1:0];
      end
    endfunction

    function void note_reference(logic [pffrs_pkg::PAGE_W-1:0] page);
      pffrs_pkg::result_t res;
      int unsigned        gap;
      logic [63:0]        page_bit;
      logic [63:0]        drop;
      res = '0;
      gap = refs_since_fault + 1;
      refs_since_fault = (gap > 65535) ? 65535 : gap;
      references++;
      if (page > page_count) begin
        res.invalid_reference = 1'b1;
        invalid_refs++;
      end else begin
        page_bit = 64'd1 << page;
        if ((resident & page_bit) != '0) begin
          used |= page_bit;
        end else begin
          res.page_fault = 1'b1;
          faults++;
          if (gap > fault_interval) begin
            // pages untouched since the previous fault leave the set
            drop = resident & ~used;
            res.window_trimmed = 1'b1;
            res.pages_evicted  = pffrs_pkg::COUNT_W'($countones(drop));
            resident &= ~drop;
            trims++;
          end
          resident |= page_bit;
          used = page_bit;
          refs_since_fault = 0;
          if (fault_total != '1) fault_total++;
        end
      end
      res.resident_count = pffrs_pkg::COUNT_W'($countones(resident));
      res.total_faults   = fault_total;
      expected_results = {expected_results, res};
    endfunction

    task report_mismatch(input string what, input longint unsigned got,
                         input longint unsigned want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
    endtask

    task check_result(input logic [pffrs_pkg::OUT_TDATA_W-1:0] data);
      pffrs_pkg::result_t got;
      pffrs_pkg::result_t want;
      got = data[$bits(pffrs_pkg::result_t)-1:0];
      results_seen++;
      if (data[pffrs_pkg::OUT_TDATA_W-1:$bits(pffrs_pkg::result_t)] != '0)
        report_mismatch("pad bits",
                        data[pffrs_pkg::OUT_TDATA_W-1:$bits(pffrs_pkg::result_t)], 0);
      if (expected_results.size() == 0) begin
        report_mismatch("result with no reference pending", got.total_faults, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.page_fault !== want.page_fault)
        report_mismatch("page_fault", got.page_fault, want.page_fault);
      if (got.invalid_reference !== want.invalid_reference)
        report_mismatch("invalid_reference", got.invalid_reference, want.invalid_reference);
      if (got.window_trimmed !== want.window_trimmed)
        report_mismatch("window_trimmed", got.window_trimmed, want.window_trimmed);
      if (got.pages_evicted !== want.pages_evicted)
        report_mismatch("pages_evicted", got.pages_evicted, want.pages_evicted);
      if (got.resident_count !== want.resident_count)
        report_mismatch("resident_count", got.resident_count, want.resident_count);
      if (got.total_faults !== want.total_faults)
        report_mismatch("total_faults", got.total_faults, want.total_faults);
    endtask
  endclass

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic                              cfg_index;
  logic [pffrs_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [pffrs_pkg::IN_TDATA_W-1:0]  s_tdata;   // [5:0] page_number
  logic                              m_tvalid;
  logic                              m_tready;
  // [0] page_fault, [1] invalid_reference, [2] window_trimmed,
  // [9:3] pages_evicted, [16:10] resident_count, [48:17] total_faults
  logic [pffrs_pkg::OUT_TDATA_W-1:0] m_tdata;

  resident_set_tracker tracker = new();

  int tx_steady_left = 0;
  int rx_hold_left   = 0;
  int rx_gap_left    = 0;
  int rx_steady_left = 0;
  int rx_taken       = 0;

  page_fault_frequency_resident_set_core #(
    .PAGE_SLOTS(64)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (tx_steady_left != 0) begin
      tx_steady_left--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) begin
      tx_steady_left = 80;
      return 0;
    end
    if ($urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  // Receiver: random backpressure, plus two long hold-offs so the input stalls.
  always @(posedge clk) begin : receiver
    logic ready_next;
    logic took;
    took = m_tvalid && m_tready;
    if (took) rx_taken++;
    if (rst) begin
      ready_next = 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      ready_next = 1'b0;
    end else if (took && (rx_taken == 300 || rx_taken == 1200)) begin
      rx_hold_left = 400;
      ready_next   = 1'b0;
    end else if (rx_steady_left != 0) begin
      rx_steady_left--;
      ready_next = 1'b1;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      ready_next = 1'b0;
    end else begin
      int r;
      r = $urandom_range(0, 199);
      if (r == 0) begin
        rx_steady_left = 120;
        ready_next     = 1'b1;
      end else if (r < 120) begin
        ready_next = 1'b1;
      end else begin
        rx_gap_left = idle_length() - 1;
        ready_next  = 1'b0;
      end
    end
    m_tready <= ready_next;
  end

  // Monitor: all transactions are sampled at the same edge the block sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) tracker.note_reference(s_tdata[pffrs_pkg::PAGE_W-1:0]);
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
    end
  end

  task automatic offer_reference(input logic [pffrs_pkg::PAGE_W-1:0] page,
                                 input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : sender_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= pffrs_pkg::IN_TDATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(pffrs_pkg::IN_TDATA_W-pffrs_pkg::PAGE_W){1'b0}}, page};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // both registers back to back; only called with the block drained
  task automatic apply_settings(input logic [pffrs_pkg::INTERVAL_W-1:0] interval,
                                input logic [pffrs_pkg::PAGE_W-1:0] count);
    cfg_valid <= 1'b1;
    cfg_index <= pffrs_pkg::CFG_FAULT_INTERVAL;
    cfg_data  <= interval;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= pffrs_pkg::CFG_PAGE_COUNT;
    cfg_data  <= pffrs_pkg::CFG_DATA_W'(count);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Locality around a drifting hot spot, with uniform noise and the valid/invalid border.
  task automatic run_phase(input int n_items, input logic [pffrs_pkg::PAGE_W-1:0] count);
    int center;
    int page;
    int r;
    center = $urandom_range(0, count);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) center = $urandom_range(0, count);
      if (r < 65) begin
        page = center - 3 + $urandom_range(0, 6);
        if (page < 0) page = 0;
        if (page > 63) page = 63;
      end else if (r < 85) begin
        page = $urandom_range(0, 63);
      end else if (r < 93) begin
        page = count;
      end else begin
        page = (count + 1) % 64;
      end
      offer_reference(pffrs_pkg::PAGE_W'(page), 1'b0);
    end
  endtask

  initial begin
    int default_pages[13];
    int wide_pages[6];
    int lowered_pages[4];
    logic [pffrs_pkg::INTERVAL_W-1:0] interval;
    logic [pffrs_pkg::PAGE_W-1:0]     count;

    default_pages = '{0, 0, 10, 11, 63, 10, 5, 3, 5, 8, 8, 8, 1};
    wide_pages    = '{63, 42, 21, 63, 42, 0};
    lowered_pages = '{63, 42, 0, 1};

    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= pffrs_pkg::CFG_FAULT_INTERVAL;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: growth without trimming, exact gap edge, trimming fault, invalid pages
    foreach (default_pages[i])
      offer_reference(pffrs_pkg::PAGE_W'(default_pages[i]), 1'b0);
    drain();
    apply_settings('0, 6'd63);
    foreach (wide_pages[i]) offer_reference(pffrs_pkg::PAGE_W'(wide_pages[i]), 1'b0);
    drain();
    // lowered page count leaves high pages resident but unreachable
    apply_settings('1, 6'd0);
    foreach (lowered_pages[i])
      offer_reference(pffrs_pkg::PAGE_W'(lowered_pages[i]), 1'b0);
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin interval = '0;    count = 6'd63; end
        1: begin interval = '1;    count = 6'd63; end
        2: begin interval = 16'd3; count = 6'd0;  end
        3: begin interval = 16'd1; count = 6'd5;  end
        default: begin
          case ($urandom_range(0, 3))
            0: interval = pffrs_pkg::INTERVAL_W'($urandom_range(0, 8));
            1: interval = pffrs_pkg::INTERVAL_W'($urandom_range(9, 200));
            2: interval = pffrs_pkg::INTERVAL_W'($urandom);
            default: interval = $urandom_range(0, 1) ? '1 : '0;
          endcase
          count = $urandom_range(0, 1) ? pffrs_pkg::PAGE_W'($urandom_range(0, 63)) : 6'd63;
        end
      endcase
      apply_settings(interval, count);
      run_phase(170, count);
      drain();
    end

    $display("covered %0d references (%0d faults, %0d trimming, %0d invalid), %0d register writes",
             tracker.references, tracker.faults, tracker.trims, tracker.invalid_refs,
             tracker.register_writes);
    $display("results checked: %0d, mismatches: %0d", tracker.results_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", tracker.pending());
    $display("status: fail");
    $finish;
  end

endmodule
